// File: src/askf_pkg.sv
// ----------------------------------------------------------------------------
// askf_pkg
// Shared constants, types and the sequencer program of the ADC scalar
// Kalman filter.
// ----------------------------------------------------------------------------
package askf_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 24;

  localparam int K_W     = FRAC_BITS + 1;
  localparam int PROD_W  = 32 + K_W;
  localparam int VAL_SH  = 32 - FRAC_BITS;
  localparam int CNT_W   = $clog2(FRAC_BITS + 1);
  localparam int PC_W    = 4;
  localparam int ADDR_W  = 4;

  localparam logic [K_W-1:0]   ONE_FX   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(FRAC_BITS);

  localparam logic [31:0] GAIN_RESET  = 32'd20766875;
  localparam logic [31:0] QNOISE_RESET = 32'd167772;
  localparam logic [31:0] RNOISE_RESET = 32'd1677722;
  localparam logic [31:0] EV_RESET    = 32'(64'd10 << FRAC_BITS);

  localparam logic [1:0] REG_SCALE_GAIN        = 2'd0;
  localparam logic [1:0] REG_PROCESS_NOISE     = 2'd1;
  localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd2;

  typedef enum logic [3:0] {
    OP_TAKE,
    OP_NONE,
    OP_MUL_SCALE,
    OP_LOAD_VAL,
    OP_ADD_Q,
    OP_ADD_R,
    OP_DIV_FIRST,
    OP_DIV_STEP,
    OP_K_ONE,
    OP_DIFF,
    OP_MUL_CORR,
    OP_UPD_EST,
    OP_MUL_VAR,
    OP_UPD_VAR,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_WAIT_IN,
    C_DEN_ZERO,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic den_zero;
    logic div_more;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [31:0] scale_gain;
    logic [31:0] process_noise;
    logic [31:0] measurement_noise;
  } cfg_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{OP_TAKE,      C_WAIT_IN,  4'd0};
      4'd1:    w = '{OP_MUL_SCALE, C_NEXT,     4'd0};
      4'd2:    w = '{OP_LOAD_VAL,  C_NEXT,     4'd0};
      4'd3:    w = '{OP_ADD_Q,     C_NEXT,     4'd0};
      4'd4:    w = '{OP_ADD_R,     C_NEXT,     4'd0};
      4'd5:    w = '{OP_NONE,      C_DEN_ZERO, 4'd14};
      4'd6:    w = '{OP_DIV_FIRST, C_NEXT,     4'd0};
      4'd7:    w = '{OP_DIV_STEP,  C_DIV_MORE, 4'd7};
      4'd8:    w = '{OP_DIFF,      C_NEXT,     4'd0};
      4'd9:    w = '{OP_MUL_CORR,  C_NEXT,     4'd0};
      4'd10:   w = '{OP_UPD_EST,   C_NEXT,     4'd0};
      4'd11:   w = '{OP_MUL_VAR,   C_NEXT,     4'd0};
      4'd12:   w = '{OP_UPD_VAR,   C_ALWAYS,   4'd15};
      4'd14:   w = '{OP_K_ONE,     C_ALWAYS,   4'd8};
      4'd15:   w = '{OP_OUT,       C_OUT_BUSY, 4'd15};
      default: w = '{OP_NONE,      C_ALWAYS,   4'd0};
    endcase
    return w;
  endfunction

endpackage

// File: src/askf_regs.sv
// ----------------------------------------------------------------------------
// askf_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module askf_regs
  import askf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_gain        <= GAIN_RESET;
      cfg_q.process_noise     <= QNOISE_RESET;
      cfg_q.measurement_noise <= RNOISE_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_SCALE_GAIN:        cfg_q.scale_gain        <= pwdata;
        REG_PROCESS_NOISE:     cfg_q.process_noise     <= pwdata;
        REG_MEASUREMENT_NOISE: cfg_q.measurement_noise <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCALE_GAIN:        prdata = cfg_q.scale_gain;
      REG_PROCESS_NOISE:     prdata = cfg_q.process_noise;
      REG_MEASUREMENT_NOISE: prdata = cfg_q.measurement_noise;
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// File: src/askf_sequencer.sv
// ----------------------------------------------------------------------------
// askf_sequencer
// Step counter and program table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module askf_sequencer
  import askf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output op_e     op_o,
  output logic    in_stall_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          cw;
  logic            jump;

  always_comb begin
    cw = ucode_rom(pc_q);
    unique case (cw.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_WAIT_IN:  jump = !in_valid_i;
      C_DEN_ZERO: jump = status_i.den_zero;
      C_DIV_MORE: jump = status_i.div_more;
      C_OUT_BUSY: jump = status_i.out_busy;
      default:    jump = 1'b0;
    endcase
    pc_d       = jump ? cw.target : pc_q + 1'b1;
    op_o       = cw.op;
    in_stall_o = cw.cond != C_WAIT_IN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: src/askf_datapath.sv
// ----------------------------------------------------------------------------
// askf_datapath
// Shared multiplier, restoring divider step, filter state and output word.
// ----------------------------------------------------------------------------
module askf_datapath
  import askf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  op_e                    op_i,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  input  logic [SAMPLE_BITS-1:0] raw_code_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [31:0]            filtered_value_o,
  output status_t                status_o
);

  logic [SAMPLE_BITS-1:0] raw_q;
  logic [31:0]            val_q, p_q, mag_q, est_q, ev_q, res_q;
  logic [32:0]            den_q, rem_q;
  logic [K_W-1:0]         k_q;
  logic [PROD_W-1:0]      prod_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   up_q, out_valid_q;

  logic [31:0]       mul_a;
  logic [K_W-1:0]    mul_b;
  logic [32:0]       var_sum;
  logic [33:0]       shl;
  logic              bit_ge, first_ge, out_busy, fire;
  logic [31:0]       corr;

  assign out_busy = out_valid_q && out_stall_i;
  assign fire     = (op_i == OP_OUT) && !out_busy;
  assign status_o = '{den_zero: den_q == 33'd0, div_more: cnt_q != CNT_W'(1),
                      out_busy: out_busy};
  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = res_q;

  always_comb begin
    case (op_i)
      OP_MUL_SCALE: begin
        mul_a = cfg_i.scale_gain;
        mul_b = K_W'(raw_q);
      end
      OP_MUL_CORR: begin
        mul_a = mag_q;
        mul_b = k_q;
      end
      default: begin
        mul_a = p_q;
        mul_b = ONE_FX - k_q;
      end
    endcase
    var_sum  = {1'b0, ev_q} + {1'b0, cfg_i.process_noise};
    first_ge = {1'b0, p_q} >= den_q;
    shl      = {rem_q, 1'b0};
    bit_ge   = shl >= {1'b0, den_q};
    corr     = prod_q[FRAC_BITS+31:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_TAKE:      if (in_valid_i) raw_q <= raw_code_i;
      OP_MUL_SCALE: prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      OP_LOAD_VAL:  val_q <= (|prod_q[PROD_W-1:VAL_SH+32]) ? 32'hFFFF_FFFF
                                                           : prod_q[VAL_SH+31:VAL_SH];
      OP_ADD_Q:     p_q <= var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];
      OP_ADD_R:     den_q <= {1'b0, p_q} + {1'b0, cfg_i.measurement_noise};
      OP_DIV_FIRST: begin
        rem_q <= first_ge ? {1'b0, p_q} - den_q : {1'b0, p_q};
        k_q   <= K_W'(first_ge);
        cnt_q <= DIV_STEPS;
      end
      OP_DIV_STEP: begin
        rem_q <= bit_ge ? 33'(shl - {1'b0, den_q}) : shl[32:0];
        k_q   <= {k_q[K_W-2:0], bit_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      OP_K_ONE:     k_q <= ONE_FX;
      OP_DIFF: begin
        up_q  <= val_q >= est_q;
        mag_q <= (val_q >= est_q) ? val_q - est_q : est_q - val_q;
      end
      OP_MUL_CORR:  prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      OP_MUL_VAR:   prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      OP_OUT:       if (fire) res_q <= est_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q       <= '0;
      ev_q        <= EV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_UPD_EST) begin
        est_q <= up_q ? est_q + corr : ((corr >= est_q) ? 32'd0 : est_q - corr);
      end
      if (op_i == OP_UPD_VAR) begin
        ev_q <= (|prod_q[PROD_W-1:FRAC_BITS+32]) ? 32'hFFFF_FFFF
                                                 : prod_q[FRAC_BITS+31:FRAC_BITS];
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: src/adc_scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// adc_scalar_kalman_filter_unit
// Gain: computed by the 24-step restoring divider; when p + r is zero the
//   divider is skipped and the gain is set to one.
// Samples: the sequencer runs one sample at a time and takes the next while
//   the result word waits in its register.
// Reset: estimate clears to zero, variance to 10.0, registers to defaults.
// ----------------------------------------------------------------------------
module adc_scalar_kalman_filter_unit
  import askf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] raw_code_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [31:0]            filtered_value_o
);

  cfg_t    cfg;
  status_t status;
  op_e     op;

  askf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  askf_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .op_o       (op),
    .in_stall_o (in_stall_o)
  );

  askf_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .raw_code_i       (raw_code_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .filtered_value_o (filtered_value_o),
    .status_o         (status)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADC scalar Kalman filter. A table of directed
// samples and register writes runs first, then random phases that each write
// new noise and gain settings. A bit-exact predictor in the bench tracks the
// estimate and variance, and each result word is checked in order against it
// or a table golden. Both channels idle and stall at random; registers are read back.
// ----------------------------------------------------------------------------
module tb_top;
  import askf_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PLAN_LEN   = 29;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 88;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 40;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [1:0]             reg_idx;
    logic [31:0]            wdata;
    logic [SAMPLE_BITS-1:0] code;
    logic                   known;
    logic [31:0]            golden;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [ADDR_W-1:0]      paddr       = '0;
  logic [31:0]            pwdata      = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] raw_code_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [31:0]            filtered_value_o;

  logic [31:0] cfg_gain   = GAIN_RESET;
  logic [31:0] cfg_qnoise = QNOISE_RESET;
  logic [31:0] cfg_rnoise = RNOISE_RESET;
  logic [31:0] mdl_estimate = '0;
  logic [31:0] mdl_variance = EV_RESET;

  logic [31:0] pending_estimates [$];
  logic [32:0] sample_notes [$];

  bit steady = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int miss_count = 0;
  int samples_taken = 0;
  int results_seen = 0;
  int writes_done = 0;
  int zero_den_steps = 0;
  int clipped_inputs = 0;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h000, 1'b1, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'hFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h001, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h800, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h555, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'hAAA, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_SCALE_GAIN,        32'hFFFFFFFF, 12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_PROCESS_NOISE,     32'h0,        12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_MEASUREMENT_NOISE, 32'h0,        12'h000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'hFFF, 1'b1, 32'hFFFFFFFF},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h000, 1'b1, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'hFFF, 1'b1, 32'hFFFFFFFF},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h001, 1'b1, 32'h00FFFFFF},
    '{ROW_WRITE,  REG_SCALE_GAIN,        32'h0,        12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_PROCESS_NOISE,     32'hFFFFFFFF, 12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_MEASUREMENT_NOISE, 32'hFFFFFFFF, 12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_UNUSED,            32'h12345678, 12'h000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'hFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_SCALE_GAIN,        32'h1,        12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_PROCESS_NOISE,     32'h0,        12'h000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'hFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'hFFF, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_SCALE_GAIN,        32'd692229,   12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_PROCESS_NOISE,     32'd8389,     12'h000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_MEASUREMENT_NOISE, 32'd167772,   12'h000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'hFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h7FF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_SCALE_GAIN,        32'h0,        12'h001, 1'b0, 32'h0}
  };

  adc_scalar_kalman_filter_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_code_i       (raw_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_value_o (filtered_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  function automatic logic [31:0] kalman_step(input logic [SAMPLE_BITS-1:0] code);
    logic [63:0] scaled;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] k;
    logic [63:0] mag;
    logic [63:0] corr;
    logic [63:0] nxt;
    logic [31:0] value;
    scaled = (64'(code) * 64'(cfg_gain)) >> VAL_SH;
    if (scaled > 64'hFFFFFFFF) clipped_inputs++;
    value = sat32(scaled);
    p = 64'(sat32(64'(mdl_variance) + 64'(cfg_qnoise)));
    den = p + 64'(cfg_rnoise);
    if (den == 64'd0) begin
      zero_den_steps++;
      k = 64'(ONE_FX);
    end else begin
      k = (p << FRAC_BITS) / den;
    end
    if (value >= mdl_estimate) begin
      mag = 64'(value - mdl_estimate);
      corr = (k * mag) >> FRAC_BITS;
      nxt = 64'(mdl_estimate) + corr;
    end else begin
      mag = 64'(mdl_estimate - value);
      corr = (k * mag) >> FRAC_BITS;
      nxt = (corr >= 64'(mdl_estimate)) ? 64'd0 : 64'(mdl_estimate) - corr;
    end
    mdl_estimate = sat32(nxt);
    mdl_variance = sat32(((64'(ONE_FX) - k) * p) >> FRAC_BITS);
    return mdl_estimate;
  endfunction

  function automatic logic [31:0] draw_noise();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 32'h0100_0000);
      1: return $urandom;
      2: return 32'h0;
      3: return 32'hFFFFFFFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic report_miss(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    miss_count++;
    if (miss_count <= 10)
      $display("mismatch (%s): expected %h, got %h", what, want, got);
  endtask

  // Hold the sender off until every pending word has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [SAMPLE_BITS-1:0] code, input logic known,
                             input logic [31:0] golden);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_notes.push_back({known, golden});
    in_valid_i <= 1'b1;
    raw_code_i <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] back;
    logic [31:0] want;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_SCALE_GAIN:        cfg_gain   = data;
      REG_PROCESS_NOISE:     cfg_qnoise = data;
      REG_MEASUREMENT_NOISE: cfg_rnoise = data;
      default: ;
    endcase
    writes_done++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (idx != REG_UNUSED) begin
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      back = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
      case (idx)
        REG_SCALE_GAIN:    want = cfg_gain;
        REG_PROCESS_NOISE: want = cfg_qnoise;
        default:           want = cfg_rnoise;
      endcase
      if (back !== want) report_miss("register readback", want, back);
    end
  endtask

  // Result checking and prediction of accepted samples.
  always @(posedge clk_i) begin
    logic [32:0] note;
    logic [31:0] predicted;
    logic [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_estimates.size() == 0) begin
          report_miss("word with nothing pending", 32'h0, filtered_value_o);
        end else begin
          want = pending_estimates.pop_front();
          if (filtered_value_o !== want) report_miss("filtered_value", want, filtered_value_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        samples_taken++;
        note = sample_notes.pop_front();
        predicted = kalman_step(raw_code_i);
        pending_estimates.push_back(note[32] ? note[31:0] : predicted);
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && !out_stall_i)
      stall_left = steady ? 0 : $urandom_range(0, 11);
    else if (stall_left != 0)
      stall_left--;
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d words pending",
               IDLE_LIMIT, pending_estimates.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int ph;
    int i;
    int level;
    int code;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_WRITE)
        write_reg(plan[i].reg_idx, plan[i].wdata);
      else
        push_sample(plan[i].code, plan[i].known, plan[i].golden);
    end

    level = $urandom_range(0, 4095);
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_SCALE_GAIN, 32'hFFFFFFFF);
          write_reg(REG_PROCESS_NOISE, 32'hFFFFFFFF);
          write_reg(REG_MEASUREMENT_NOISE, 32'hFFFFFFFF);
        end
        2: begin
          write_reg(REG_SCALE_GAIN, $urandom_range(0, 32'h0200_0000));
          write_reg(REG_PROCESS_NOISE, 32'h0);
          write_reg(REG_MEASUREMENT_NOISE, 32'h0);
        end
        3: begin
          write_reg(REG_SCALE_GAIN, 32'h0);
          write_reg(REG_PROCESS_NOISE, $urandom_range(0, 32'h0100_0000));
          write_reg(REG_MEASUREMENT_NOISE, $urandom_range(0, 32'h0100_0000));
        end
        default: begin
          case ($urandom_range(0, 2))
            0: write_reg(REG_SCALE_GAIN, $urandom_range(0, 32'h0400_0000));
            1: write_reg(REG_SCALE_GAIN, $urandom);
            default: write_reg(REG_SCALE_GAIN, $urandom_range(0, 32'h1000_0000));
          endcase
          write_reg(REG_PROCESS_NOISE, draw_noise());
          write_reg(REG_MEASUREMENT_NOISE, draw_noise());
          if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, $urandom);
        end
      endcase
      for (i = 0; i < PHASE_LEN; i++) begin
        if (i % 22 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 39) == 0) wait_idle();
        if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 4095);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            code = level + $urandom_range(0, 64) - 32;
            if (code < 0) code = 0;
            if (code > 4095) code = 4095;
          end
          4, 5, 6: code = $urandom_range(0, 4095);
          7:       code = 0;
          8:       code = 4095;
          default: code = 1 << $urandom_range(0, SAMPLE_BITS - 1);
        endcase
        push_sample(code[SAMPLE_BITS-1:0], 1'b0, 32'h0);
      end
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("summary: %0d samples, %0d result words, %0d register writes",
             samples_taken, results_seen, writes_done);
    $display("summary: %0d zero-denominator steps, %0d clipped inputs, %0d mismatches",
             zero_den_steps, clipped_inputs, miss_count);
    if (miss_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// File: adc_scalar_kalman_filter_unit.f
src/askf_pkg.sv
src/askf_regs.sv
src/askf_sequencer.sv
src/askf_datapath.sv
src/adc_scalar_kalman_filter_unit.sv
verif/tb_top.sv
